// ----- hdl/grl_pkg.sv -----
// glyph run layout package: types, register map, reset values and arithmetic helpers
`timescale 1ns / 1ps

package grl_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_FINISH = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_SIZE_PX    = 3'd0,
    REG_PEN_X      = 3'd1,
    REG_PEN_Y      = 3'd2,
    REG_LINE_ADV   = 3'd3,
    REG_DIST_RANGE = 3'd4,
    REG_DENSITY    = 3'd5,
    REG_TINT       = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    RNG_IDLE,
    RNG_MUL,
    RNG_SEL,
    RNG_DIV
  } rng_state_e;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam int unsigned SCALE_W      = 24;
  localparam int unsigned QUO_W        = 16;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned NUM_W        = 34;

  localparam logic [15:0] SIZE_PX_RST    = 16'd1024;
  localparam logic [31:0] PEN_X_RST      = 32'd0;
  localparam logic [31:0] PEN_Y_RST      = 32'd0;
  localparam logic [15:0] LINE_ADV_RST   = 16'd4915;
  localparam logic [15:0] DIST_RANGE_RST = 16'd1024;
  localparam logic [15:0] DENSITY_RST    = 16'd8192;
  localparam logic [31:0] TINT_RST       = 32'hFFFF_FFFF;
  localparam logic [15:0] RANGE_RST      = 16'd512;

  typedef struct packed {
    logic               inked;
    logic        [15:0] tex_max_v;
    logic        [15:0] tex_max_u;
    logic        [15:0] tex_min_v;
    logic        [15:0] tex_min_u;
    logic signed [15:0] box_top;
    logic signed [15:0] box_right;
    logic signed [15:0] box_bottom;
    logic signed [15:0] box_left;
    logic signed [15:0] advance;
  } glyph_entry_t;

  // em value times size, floored to q.8
  function automatic logic signed [SCALE_W-1:0] em_scale(input logic signed [16:0] em,
                                                          input logic [15:0] size);
    logic signed [33:0] prod;
    prod = 34'(em) * 34'($signed({1'b0, size}));
    return prod[33:10];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      return $signed(v[31:0]);
    end else if (v[33]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

// ----- hdl/glyph_run_layout.sv -----
// glyph run layout top level: glyph table memory, scaling pipeline and cursor
`timescale 1ns / 1ps

// Lays out a stream of glyph table loads, character codes and finish beats as
// screen quads. Input beats arrive on s_axis (kind in tuser, fields in tdata),
// results leave on m_axis (is_end in tuser, quad fields in tdata). Loads and
// absent, uninked or newline characters give no output beat; an inked glyph
// gives one quad beat and a finish gives one end beat carrying the cursor x.
// One beat is taken per clock while m_axis does not stall, no range recompute
// runs and no register write is under way. A result passes through the glyph
// table read, the em scaling multipliers, then the cursor add and saturation
// into the output register. The cursor loop closes within that last stage, so
// characters stream without gaps. When m_axis stalls, the whole pipeline holds
// and s_axis_tready drops. Writes to size_px, distance_range or atlas_density
// recompute the screen range: a multiply state, a check state and a 16-step
// divide, during which s_axis_tready stays low. Reset clears the glyph presence
// bits at once, loads the register defaults, puts the cursor at the origin and
// needs no clearing pass. Registers sit at byte addresses 4*index.
module glyph_run_layout #(
  parameter int unsigned GLYPH_ENTRIES = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // code, advance, box_left, box_bottom, box_right, box_top,
  // tex_min_u, tex_min_v, tex_max_u, tex_max_v, inked
  input  logic [159:0] s_axis_tdata,
  // kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // quad_x, quad_y, quad_w, quad_h, out_min_u, out_min_v, out_max_u,
  // out_max_v, screen_range, quad_color
  output logic [239:0] m_axis_tdata,
  // is_end
  output logic [0:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import grl_pkg::*;

  localparam int unsigned IdxW = $clog2(GLYPH_ENTRIES);

  // configuration registers
  logic [15:0]        size_q, line_q, drange_q, dens_q;
  logic signed [31:0] pen_x_q, pen_y_q;
  logic [31:0]        tint_q;
  logic               cfg_wr;
  reg_e               cfg_idx;
  logic               rng_start, rng_busy;
  logic [15:0]        range_px;

  // input beat
  kind_e              in_kind;
  logic [7:0]         in_code;
  glyph_entry_t       in_entry;
  logic [IdxW-1:0]    in_idx;
  logic               in_range;
  logic               accept, stall;

  // glyph table
  glyph_entry_t       mem [GLYPH_ENTRIES];
  logic [GLYPH_ENTRIES-1:0] present_q;

  // stage 1: table data
  logic               s1_valid_q, s1_nl_q, s1_hit_q;
  kind_e              s1_kind_q;
  glyph_entry_t       rd_q;

  // stage 2: scaled values
  logic               s2_valid_q, s2_nl_q, s2_hit_q, s2_ink_q;
  kind_e              s2_kind_q;
  logic signed [SCALE_W-1:0] sc_left_q, sc_top_q, sc_w_q, sc_h_q, sc_adv_q, sc_line_q;
  logic [63:0]        tex_q;

  // cursor and output
  logic signed [31:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic               emit, emit_end;
  logic signed [31:0] qx, qy;
  logic               out_valid_q;
  logic [239:0]       out_data_q, out_data_d;
  logic               out_end_q;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= SIZE_PX_RST;
      pen_x_q  <= PEN_X_RST;
      pen_y_q  <= PEN_Y_RST;
      line_q   <= LINE_ADV_RST;
      drange_q <= DIST_RANGE_RST;
      dens_q   <= DENSITY_RST;
      tint_q   <= TINT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SIZE_PX:    size_q   <= pwdata[15:0];
        REG_PEN_X:      pen_x_q  <= pwdata;
        REG_PEN_Y:      pen_y_q  <= pwdata;
        REG_LINE_ADV:   line_q   <= pwdata[15:0];
        REG_DIST_RANGE: drange_q <= pwdata[15:0];
        REG_DENSITY:    dens_q   <= pwdata[15:0];
        REG_TINT:       tint_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SIZE_PX:    prdata = 32'(size_q);
      REG_PEN_X:      prdata = pen_x_q;
      REG_PEN_Y:      prdata = pen_y_q;
      REG_LINE_ADV:   prdata = 32'(line_q);
      REG_DIST_RANGE: prdata = 32'(drange_q);
      REG_DENSITY:    prdata = 32'(dens_q);
      REG_TINT:       prdata = tint_q;
      default:        prdata = '0;
    endcase
  end

  assign rng_start = cfg_wr && (cfg_idx == REG_SIZE_PX || cfg_idx == REG_DIST_RANGE ||
                                cfg_idx == REG_DENSITY);

  grl_range u_range (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (rng_start),
    .size_px_i    (size_q),
    .dist_range_i (drange_q),
    .density_i    (dens_q),
    .busy_o       (rng_busy),
    .range_o      (range_px)
  );

  // input unpacking
  assign in_kind  = kind_e'(s_axis_tuser);
  assign in_code  = s_axis_tdata[7:0];
  assign in_entry = {s_axis_tdata[152], s_axis_tdata[151:136], s_axis_tdata[135:120],
                     s_axis_tdata[119:104], s_axis_tdata[103:88], s_axis_tdata[87:72],
                     s_axis_tdata[71:56], s_axis_tdata[55:40], s_axis_tdata[39:24],
                     s_axis_tdata[23:8]};
  assign in_idx   = in_code[IdxW-1:0];
  assign in_range = {1'b0, in_code} < 9'(GLYPH_ENTRIES);

  assign stall         = out_valid_q && !m_axis_tready;
  assign s_axis_tready = !stall && !rng_busy && !cfg_wr;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // table write on load, registered read for every beat
  always_ff @(posedge clk_i) begin
    if (accept && in_kind == KIND_LOAD && in_range) begin
      mem[in_idx] <= in_entry;
    end
    if (accept) begin
      rd_q <= mem[in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (accept && in_kind == KIND_LOAD && in_range) begin
      present_q[in_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_kind_q  <= KIND_LOAD;
      s1_nl_q    <= 1'b0;
      s1_hit_q   <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_kind_q  <= KIND_LOAD;
      s2_nl_q    <= 1'b0;
      s2_hit_q   <= 1'b0;
      s2_ink_q   <= 1'b0;
    end else if (!stall) begin
      s1_valid_q <= accept;
      s1_kind_q  <= in_kind;
      s1_nl_q    <= in_code == NEWLINE_CODE;
      s1_hit_q   <= in_range && present_q[in_idx];
      s2_valid_q <= s1_valid_q;
      s2_kind_q  <= s1_kind_q;
      s2_nl_q    <= s1_nl_q;
      s2_hit_q   <= s1_hit_q;
      s2_ink_q   <= rd_q.inked;
    end
  end

  // em scaling
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      sc_left_q <= em_scale(17'(rd_q.box_left), size_q);
      sc_top_q  <= em_scale(17'(rd_q.box_top), size_q);
      sc_w_q    <= em_scale(17'(rd_q.box_right) - 17'(rd_q.box_left), size_q);
      sc_h_q    <= em_scale(17'(rd_q.box_top) - 17'(rd_q.box_bottom), size_q);
      sc_adv_q  <= em_scale(17'(rd_q.advance), size_q);
      sc_line_q <= em_scale($signed({1'b0, line_q}), size_q);
      tex_q     <= {rd_q.tex_max_v, rd_q.tex_max_u, rd_q.tex_min_v, rd_q.tex_min_u};
    end
  end

  // cursor stage
  assign qx = sat32(34'(cur_x_q) + 34'(sc_left_q));
  assign qy = sat32(34'(cur_y_q) - 34'(sc_top_q));

  always_comb begin
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    emit       = 1'b0;
    emit_end   = 1'b0;
    out_data_d = '0;
    if (s2_valid_q) begin
      unique case (s2_kind_q)
        KIND_FINISH: begin
          emit             = 1'b1;
          emit_end         = 1'b1;
          out_data_d[31:0] = cur_x_q;
          cur_x_d          = pen_x_q;
          cur_y_d          = pen_y_q;
        end
        KIND_CHAR: begin
          if (s2_nl_q) begin
            cur_x_d = pen_x_q;
            cur_y_d = sat32(34'(cur_y_q) + 34'(sc_line_q));
          end else if (s2_hit_q) begin
            cur_x_d = sat32(34'(cur_x_q) + 34'(sc_adv_q));
            if (s2_ink_q) begin
              emit       = 1'b1;
              out_data_d = {tint_q, range_px, tex_q, 32'(sc_h_q), 32'(sc_w_q), qy, qx};
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= PEN_X_RST;
      cur_y_q     <= PEN_Y_RST;
      out_valid_q <= 1'b0;
      out_end_q   <= 1'b0;
    end else begin
      if (cfg_wr && cfg_idx == REG_PEN_X) begin
        cur_x_q <= pwdata;
      end else if (!stall) begin
        cur_x_q <= cur_x_d;
      end
      if (cfg_wr && cfg_idx == REG_PEN_Y) begin
        cur_y_q <= pwdata;
      end else if (!stall) begin
        cur_y_q <= cur_y_d;
      end
      if (!stall) begin
        out_valid_q <= emit;
        out_end_q   <= emit_end;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_end_q;

endmodule

// ----- hdl/grl_range.sv -----
// screen distance range unit: multiply then bit-serial divide with saturation
`timescale 1ns / 1ps

module grl_range (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] size_px_i,
  input  logic [15:0] dist_range_i,
  input  logic [15:0] density_i,
  output logic        busy_o,
  output logic [15:0] range_o
);
  import grl_pkg::*;

  rng_state_e state_q, state_d;
  logic [NUM_W-1:0] num_q;
  logic [15:0]      rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic [15:0]      range_q;

  logic             do_mul, do_sel, do_step;
  logic [16:0]      trial;
  logic             ge;
  logic [15:0]      rem_step;
  logic [QUO_W-1:0] quo_step;
  logic             last_step;
  logic             overflow;

  assign trial     = {rem_q, quo_q[QUO_W-1]};
  assign ge        = trial >= {1'b0, density_i};
  assign rem_step  = ge ? 16'(trial - {1'b0, density_i}) : trial[15:0];
  assign quo_step  = {quo_q[QUO_W-2:0], ge};
  assign last_step = cnt_q == CNT_W'(QUO_W - 1);
  assign overflow  = num_q[NUM_W-1:QUO_W] >= {2'b00, density_i};

  always_comb begin
    state_d = state_q;
    if (start_i) begin
      state_d = RNG_MUL;
    end else begin
      unique case (state_q)
        RNG_IDLE: state_d = RNG_IDLE;
        RNG_MUL:  state_d = RNG_SEL;
        RNG_SEL:  state_d = (density_i == '0 || overflow) ? RNG_IDLE : RNG_DIV;
        RNG_DIV:  state_d = last_step ? RNG_IDLE : RNG_DIV;
        default:  state_d = RNG_IDLE;
      endcase
    end
  end

  always_comb begin
    busy_o  = state_q != RNG_IDLE;
    do_mul  = state_q == RNG_MUL;
    do_sel  = state_q == RNG_SEL;
    do_step = state_q == RNG_DIV;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RNG_IDLE;
      cnt_q   <= '0;
      range_q <= RANGE_RST;
    end else begin
      state_q <= state_d;
      if (do_sel) begin
        cnt_q <= '0;
        if (density_i == '0) begin
          range_q <= dist_range_i;
        end else if (overflow) begin
          range_q <= 16'hFFFF;
        end
      end else if (do_step) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          range_q <= quo_step;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_mul) begin
      num_q <= {32'(dist_range_i) * 32'(size_px_i), 2'b00};
    end
    if (do_sel) begin
      rem_q <= num_q[QUO_W+15:QUO_W];
      quo_q <= num_q[QUO_W-1:0];
    end else if (do_step) begin
      rem_q <= rem_step;
      quo_q <= quo_step;
    end
  end

  assign range_o = range_q;

endmodule

// ----- bench/tb_glyph_run_layout.sv -----
// testbench for glyph_run_layout: predicts quads and end beats and checks every result beat
`timescale 1ns / 1ps

module tb_glyph_run_layout;
  import grl_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic        is_end;
    logic [31:0] color;
    logic [15:0] scr_range;
    logic [15:0] max_v;
    logic [15:0] max_u;
    logic [15:0] min_v;
    logic [15:0] min_u;
    logic [31:0] h;
    logic [31:0] w;
    logic [31:0] y;
    logic [31:0] x;
  } quad_t;

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  class quad_layout_model;
    logic [15:0]        size_px, line_adv, dist_range, density, range_px;
    logic signed [31:0] pen_x, pen_y;
    logic [31:0]        tint;
    logic [1:0]         present [256];
    glyph_entry_t       glyph_mem [256];
    longint             cur_x, cur_y;
    quad_t              expected_quads [$];
    int                 mismatches;

    function new();
      size_px    = SIZE_PX_RST;
      pen_x      = PEN_X_RST;
      pen_y      = PEN_Y_RST;
      line_adv   = LINE_ADV_RST;
      dist_range = DIST_RANGE_RST;
      density    = DENSITY_RST;
      tint       = TINT_RST;
      foreach (present[i]) present[i] = 2'b00;
      cur_x      = 0;
      cur_y      = 0;
      mismatches = 0;
      update_range();
    endfunction

    function longint scale_em(longint em);
      longint prod;
      prod = em * longint'(size_px);
      return prod >>> 10;
    endfunction

    function void update_range();
      longint unsigned quo;
      if (density == 16'd0) begin
        range_px = dist_range;
      end else begin
        quo = (64'(dist_range) * 64'(size_px) * 64'd4) / 64'(density);
        range_px = (quo > 64'd65535) ? 16'hFFFF : quo[15:0];
      end
    endfunction

    function void write_reg(reg_e idx, logic [31:0] value);
      case (idx)
        REG_SIZE_PX: size_px = value[15:0];
        REG_PEN_X: begin
          pen_x = value;
          cur_x = pen_x;
        end
        REG_PEN_Y: begin
          pen_y = value;
          cur_y = pen_y;
        end
        REG_LINE_ADV: line_adv = value[15:0];
        REG_DIST_RANGE: dist_range = value[15:0];
        REG_DENSITY: density = value[15:0];
        REG_TINT: tint = value;
        default: ;
      endcase
      update_range();
    endfunction

    function void take_item(logic [1:0] kind, logic [7:0] code, glyph_entry_t g);
      quad_t        q;
      glyph_entry_t e;
      longint       left, right, top, bottom;
      q = '0;
      case (kind)
        KIND_LOAD: begin
          glyph_mem[code] = g;
          present[code]   = {g.inked, 1'b1};
        end
        KIND_FINISH: begin
          q.is_end = 1'b1;
          q.x      = cur_x[31:0];
          expected_quads.insert(expected_quads.size(), q);
          cur_x = pen_x;
          cur_y = pen_y;
        end
        KIND_CHAR: begin
          if (code == NEWLINE_CODE) begin
            cur_x = pen_x;
            cur_y = $signed(clip32(cur_y + scale_em(longint'(line_adv))));
          end else if (present[code][0]) begin
            e = glyph_mem[code];
            if (present[code][1]) begin
              left      = $signed(e.box_left);
              right     = $signed(e.box_right);
              top       = $signed(e.box_top);
              bottom    = $signed(e.box_bottom);
              q.x         = clip32(cur_x + scale_em(left));
              q.y         = clip32(cur_y - scale_em(top));
              q.w         = clip32(scale_em(right - left));
              q.h         = clip32(scale_em(top - bottom));
              q.min_u     = e.tex_min_u;
              q.min_v     = e.tex_min_v;
              q.max_u     = e.tex_max_u;
              q.max_v     = e.tex_max_v;
              q.scr_range = range_px;
              q.color     = tint;
              expected_quads.insert(expected_quads.size(), q);
            end
            cur_x = $signed(clip32(cur_x + scale_em(longint'($signed(e.advance)))));
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_beat(quad_t got);
      quad_t want;
      if (expected_quads.size() == 0) begin
        $display("%0t ns: result beat with none expected, got %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_quads.pop_front();
      compare_field("is_end", want.is_end, got.is_end);
      compare_field("quad_x", want.x, got.x);
      compare_field("quad_y", want.y, got.y);
      compare_field("quad_w", want.w, got.w);
      compare_field("quad_h", want.h, got.h);
      compare_field("out_min_u", want.min_u, got.min_u);
      compare_field("out_min_v", want.min_v, got.min_v);
      compare_field("out_max_u", want.max_u, got.max_u);
      compare_field("out_max_v", want.max_v, got.max_v);
      compare_field("screen_range", want.scr_range, got.scr_range);
      compare_field("quad_color", want.color, got.color);
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // code, advance, box_left, box_bottom, box_right, box_top,
  // tex_min_u, tex_min_v, tex_max_u, tex_max_v, inked
  logic [159:0] s_axis_tdata = '0;
  // kind
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // quad_x, quad_y, quad_w, quad_h, out_min_u, out_min_v, out_max_u,
  // out_max_v, screen_range, quad_color
  logic [239:0] m_axis_tdata;
  // is_end
  logic [0:0]   m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int src_idle_pct = 22;
  int sink_idle_pct = 57;
  int cycle_count = 0;

  quad_layout_model layout = new();

  glyph_run_layout DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      layout.check_beat({m_axis_tuser, m_axis_tdata});
    end
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[glyph_run_layout] ERROR");
      $finish;
    end
  end

  function automatic glyph_entry_t make_glyph(logic signed [15:0] adv, logic signed [15:0] l,
                                              logic signed [15:0] b, logic signed [15:0] r,
                                              logic signed [15:0] t, logic [15:0] u0,
                                              logic [15:0] v0, logic [15:0] u1,
                                              logic [15:0] v1, logic ink);
    glyph_entry_t g;
    g.advance    = adv;
    g.box_left   = l;
    g.box_bottom = b;
    g.box_right  = r;
    g.box_top    = t;
    g.tex_min_u  = u0;
    g.tex_min_v  = v0;
    g.tex_max_u  = u1;
    g.tex_max_v  = v1;
    g.inked      = ink;
    return g;
  endfunction

  // half fully random fields, half plausible glyph metrics
  function automatic glyph_entry_t rand_glyph();
    logic [159:0] bits;
    glyph_entry_t g;
    int           l, b;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    g = bits[144:0];
    if ($urandom_range(0, 1) == 0) begin
      l = int'($urandom_range(0, 1024)) - 512;
      b = int'($urandom_range(0, 1024)) - 512;
      g.advance    = 16'($urandom_range(0, 6144));
      g.box_left   = 16'(l);
      g.box_bottom = 16'(b);
      g.box_right  = 16'(l + int'($urandom_range(0, 4096)));
      g.box_top    = 16'(b + int'($urandom_range(0, 4096)));
    end
    g.inked = ($urandom_range(0, 3) != 0);
    return g;
  endfunction

  function automatic logic [31:0] pick_value(int style, logic [31:0] lo, logic [31:0] hi,
                                             logic [31:0] mask);
    if (style == 0) return lo;
    if (style == 1) return hi;
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      default: return $urandom & mask;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [7:0] code,
                           input glyph_entry_t g);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'd0, g, code};
    do @(posedge clk_i); while (!s_axis_tready);
    layout.take_item(kind, code, g);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (layout.expected_quads.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // pause covers a range recompute still running from the previous write
  task automatic apb_write(input reg_e idx, input logic [31:0] value);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    layout.write_reg(idx, value);
  endtask

  task automatic set_layout(input int style);
    apb_write(REG_SIZE_PX, pick_value(style, 32'h0, 32'hFFFF, 32'h0000_FFFF));
    apb_write(REG_PEN_X, pick_value(style, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    apb_write(REG_PEN_Y, pick_value(style, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    apb_write(REG_LINE_ADV, pick_value(style, 32'h0, 32'hFFFF, 32'h0000_FFFF));
    apb_write(REG_DIST_RANGE, pick_value(style, 32'h0, 32'hFFFF, 32'h0000_FFFF));
    apb_write(REG_DENSITY, pick_value(style, 32'h0, 32'hFFFF, 32'h0000_FFFF));
    apb_write(REG_TINT, pick_value(style, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  // loads a small glyph set, then streams text over it with some noise
  task automatic run_text(input int count);
    logic [7:0] glyph_set [8];
    logic [7:0] code;
    int         roll;
    foreach (glyph_set[i]) glyph_set[i] = 8'($urandom);
    foreach (glyph_set[i]) send_item(KIND_LOAD, glyph_set[i], rand_glyph());
    for (int i = 8; i < count; i++) begin
      roll = $urandom_range(0, 99);
      code = glyph_set[$urandom_range(0, 7)];
      if (roll < 14) begin
        if ($urandom_range(0, 3) == 0) code = 8'($urandom);
        send_item(KIND_LOAD, code, rand_glyph());
      end else if (roll < 82) begin
        case ($urandom_range(0, 9))
          0: code = NEWLINE_CODE;
          1, 2: code = 8'($urandom);
          default: ;
        endcase
        send_item(KIND_CHAR, code, rand_glyph());
      end else if (roll < 97) begin
        send_item(KIND_FINISH, 8'($urandom), rand_glyph());
      end else begin
        send_item(KIND_UNUSED, 8'($urandom), rand_glyph());
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under reset settings
    send_item(KIND_CHAR, CH_A, rand_glyph());
    send_item(KIND_FINISH, CH_A, rand_glyph());
    send_item(KIND_LOAD, CH_A, make_glyph(16'sh0800, 16'sh0100, -16'sh0200, 16'sh0700,
                                          16'sh0C00, 16'h0000, 16'h0000, 16'hFFFF,
                                          16'hFFFF, 1'b1));
    send_item(KIND_CHAR, CH_A, rand_glyph());
    send_item(KIND_CHAR, CH_A, rand_glyph());
    send_item(KIND_LOAD, CH_B, make_glyph(-16'sh8000, 16'sh0010, 16'sh0020, 16'sh0400,
                                          16'sh0500, 16'h1234, 16'h5678, 16'h9ABC,
                                          16'hDEF0, 1'b0));
    send_item(KIND_CHAR, CH_B, rand_glyph());
    send_item(KIND_CHAR, NEWLINE_CODE, rand_glyph());
    send_item(KIND_LOAD, NEWLINE_CODE, make_glyph(16'sh1000, 16'sh0000, 16'sh0000,
                                                  16'sh0800, 16'sh0800, 16'h0100,
                                                  16'h0200, 16'h0300, 16'h0400, 1'b1));
    send_item(KIND_CHAR, NEWLINE_CODE, rand_glyph());
    send_item(KIND_LOAD, CH_C, make_glyph(16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF,
                                          16'sh7FFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                                          16'h0000, 1'b1));
    send_item(KIND_CHAR, CH_C, rand_glyph());
    send_item(KIND_CHAR, CH_C, rand_glyph());
    send_item(KIND_UNUSED, CH_C, rand_glyph());
    send_item(KIND_LOAD, CH_D, make_glyph(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
                                          16'sh0000, 16'h0000, 16'h0000, 16'h0000,
                                          16'h0000, 1'b1));
    send_item(KIND_CHAR, CH_D, rand_glyph());
    send_item(KIND_FINISH, CH_D, rand_glyph());
    send_item(KIND_CHAR, CH_C, rand_glyph());
    send_item(KIND_CHAR, NEWLINE_CODE, rand_glyph());
    send_item(KIND_CHAR, CH_B, rand_glyph());
    send_item(KIND_CHAR, CH_A, rand_glyph());
    send_item(KIND_FINISH, CH_A, rand_glyph());

    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          src_idle_pct  = 22;
          sink_idle_pct = 57;
        end
        1: begin
          src_idle_pct  = 57;
          sink_idle_pct = 22;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      wait_drain();
      case (phase)
        1: set_layout(0);
        3: set_layout(1);
        default: set_layout(2);
      endcase
      run_text(158);
    end

    wait_drain();
    if (layout.mismatches == 0) begin
      $display("[glyph_run_layout] OK");
    end else begin
      $display("[glyph_run_layout] ERROR");
    end
    $finish;
  end

endmodule
